FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with asynchronous low reset disable
`define RSCP_ASSERT(name, ck, rn, prop) \
    name: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("rscp assertion failed");

// Same, on the block clock and reset
`define RSCP_CLK_ASSERT(name, prop) `RSCP_ASSERT(name, clk, rst_n, prop)

`endif

FILE: rtl/rscp_pkg.sv
package rscp_pkg;

    localparam int LONG_ADDR_BYTES = 8;
    localparam int LONG_IDX_W      = $clog2(LONG_ADDR_BYTES);

    // Framing bytes and command codes
    localparam logic [7:0] SYNC_A      = 8'h7a;
    localparam logic [7:0] SYNC_B      = 8'h62;
    localparam logic [7:0] RESP_BIT    = 8'h80;
    localparam logic [7:0] OK_CODE     = 8'h00;
    localparam logic [7:0] CMD_CHANNEL = 8'h04;
    localparam logic [7:0] CMD_TX      = 8'h09;
    localparam logic [7:0] CMD_GETADDR = 8'h0d;
    localparam logic [7:0] CMD_PANID   = 8'h0f;
    localparam logic [7:0] CMD_SHORT   = 8'h10;
    localparam logic [7:0] CMD_LONG    = 8'h11;

    localparam logic [15:0] FCS_INIT = 16'h0000;
    localparam logic [15:0] FCS_POLY = 16'h8408;

    // Job queue between parser and emitter
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Emitter step counter, longest job is 4 + LONG_ADDR_BYTES words
    localparam int STEP_W = $clog2(4 + LONG_ADDR_BYTES);

    // Kinds of output jobs
    typedef enum logic [2:0] {
        JOB_BYTE,   // one payload word on the network port
        JOB_LAST,   // last payload word, FCS, success reply
        JOB_FCS,    // empty frame: FCS, success reply
        JOB_OK,     // success reply only
        JOB_ADDR    // get-address reply
    } job_kind_t;

    typedef struct packed {
        job_kind_t                          kind;
        logic [7:0]                         data;
        logic [7:0]                         cmd;
        logic [15:0]                        fcs;
        logic [15:0]                        pan_id;
        logic [15:0]                        short_addr;
        logic [LONG_ADDR_BYTES-1:0][7:0]    long_addr;
    } job_t;

endpackage

FILE: rtl/rscp_fifo.sv
module rscp_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rscp_pkg::job_t  push_job,
    input  logic            pop,
    output rscp_pkg::job_t  head_job,
    output logic            head_valid,
    output logic            full
);

    rscp_pkg::job_t                 mem [rscp_pkg::FIFO_DEPTH];
    logic [rscp_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [rscp_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [rscp_pkg::FIFO_CW-1:0]   count_reg;
    logic [rscp_pkg::FIFO_CW-1:0]   count_next;

    assign head_job   = mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == rscp_pkg::FIFO_CW'(rscp_pkg::FIFO_DEPTH));

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/rscp_front.sv
module rscp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      rx_byte,
    output logic            job_valid,
    output rscp_pkg::job_t  job
);

    typedef enum logic [2:0] {
        PH_HUNT_A,
        PH_HUNT_B,
        PH_CMD,
        PH_ARGS,
        PH_TXLEN,
        PH_PAYLOAD
    } phase_t;

    phase_t                                     phase_reg, phase_next;
    logic [7:0]                                 cmd_reg, cmd_next;
    logic [7:0]                                 arg_cnt_reg, arg_cnt_next;
    logic [7:0]                                 frame_len_reg, frame_len_next;
    logic [15:0]                                fcs_reg, fcs_next;
    logic [15:0]                                pan_reg, pan_next;
    logic [15:0]                                short_reg, short_next;
    logic [rscp_pkg::LONG_ADDR_BYTES-1:0][7:0]  long_reg, long_next;
    logic                                       emit;

    // bytewise reflected CRC, 0x8408
    function automatic logic [15:0] fcs_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ rscp_pkg::FCS_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] args_needed(input logic [7:0] cmd);
        logic [7:0] n;
        n = 8'd1;
        if (cmd == rscp_pkg::CMD_PANID || cmd == rscp_pkg::CMD_SHORT)
        begin
            n = 8'd2;
        end
        else if (cmd == rscp_pkg::CMD_LONG)
        begin
            n = 8'(rscp_pkg::LONG_ADDR_BYTES);
        end
        return n;
    endfunction

    // parser next state and job build
    always_comb
    begin
        phase_next     = phase_reg;
        cmd_next       = cmd_reg;
        arg_cnt_next   = arg_cnt_reg;
        frame_len_next = frame_len_reg;
        fcs_next       = fcs_reg;
        pan_next       = pan_reg;
        short_next     = short_reg;
        long_next      = long_reg;
        emit           = 1'b0;
        job            = '0;
        job.kind       = rscp_pkg::JOB_OK;

        case (phase_reg)
            PH_HUNT_B:
            begin
                phase_next = (rx_byte == rscp_pkg::SYNC_B) ? PH_CMD : PH_HUNT_A;
            end
            PH_CMD:
            begin
                cmd_next     = rx_byte;
                arg_cnt_next = '0;
                if (rx_byte == rscp_pkg::CMD_PANID || rx_byte == rscp_pkg::CMD_SHORT ||
                    rx_byte == rscp_pkg::CMD_LONG || rx_byte == rscp_pkg::CMD_CHANNEL)
                begin
                    phase_next = PH_ARGS;
                end
                else if (rx_byte == rscp_pkg::CMD_TX)
                begin
                    phase_next = PH_TXLEN;
                end
                else
                begin
                    emit       = 1'b1;
                    job.cmd    = rx_byte;
                    job.kind   = (rx_byte == rscp_pkg::CMD_GETADDR) ?
                                 rscp_pkg::JOB_ADDR : rscp_pkg::JOB_OK;
                    phase_next = PH_HUNT_A;
                end
            end
            PH_ARGS:
            begin
                if (cmd_reg == rscp_pkg::CMD_PANID)
                begin
                    if (arg_cnt_reg == '0)
                        pan_next[15:8] = rx_byte;
                    else
                        pan_next[7:0] = rx_byte;
                end
                else if (cmd_reg == rscp_pkg::CMD_SHORT)
                begin
                    if (arg_cnt_reg == '0)
                        short_next[15:8] = rx_byte;
                    else
                        short_next[7:0] = rx_byte;
                end
                else if (cmd_reg == rscp_pkg::CMD_LONG)
                begin
                    if (arg_cnt_reg < 8'(rscp_pkg::LONG_ADDR_BYTES))
                        long_next[arg_cnt_reg[rscp_pkg::LONG_IDX_W-1:0]] = rx_byte;
                end
                arg_cnt_next = arg_cnt_reg + 1'b1;
                if (arg_cnt_next >= args_needed(cmd_reg))
                begin
                    emit       = 1'b1;
                    job.kind   = rscp_pkg::JOB_OK;
                    job.cmd    = cmd_reg;
                    phase_next = PH_HUNT_A;
                end
            end
            PH_TXLEN:
            begin
                frame_len_next = rx_byte;
                fcs_next       = rscp_pkg::FCS_INIT;
                if (rx_byte == '0)
                begin
                    emit       = 1'b1;
                    job.kind   = rscp_pkg::JOB_FCS;
                    job.cmd    = cmd_reg;
                    job.fcs    = rscp_pkg::FCS_INIT;
                    phase_next = PH_HUNT_A;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                fcs_next       = fcs_update(fcs_reg, rx_byte);
                frame_len_next = frame_len_reg - 1'b1;
                emit           = 1'b1;
                job.data       = rx_byte;
                job.cmd        = cmd_reg;
                job.fcs        = fcs_next;
                if (frame_len_next == '0)
                begin
                    job.kind   = rscp_pkg::JOB_LAST;
                    phase_next = PH_HUNT_A;
                end
                else
                begin
                    job.kind = rscp_pkg::JOB_BYTE;
                end
            end
            default:
            begin
                phase_next = (rx_byte == rscp_pkg::SYNC_A) ? PH_HUNT_B : PH_HUNT_A;
            end
        endcase

        // addresses as they stand after this word
        job.pan_id     = pan_next;
        job.short_addr = short_next;
        job.long_addr  = long_next;
    end

    assign job_valid = take && emit;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT_A;
            cmd_reg       <= '0;
            arg_cnt_reg   <= '0;
            frame_len_reg <= '0;
            fcs_reg       <= '0;
            pan_reg       <= '0;
            short_reg     <= '0;
            long_reg      <= '0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            arg_cnt_reg   <= arg_cnt_next;
            frame_len_reg <= frame_len_next;
            fcs_reg       <= fcs_next;
            pan_reg       <= pan_next;
            short_reg     <= short_next;
            long_reg      <= long_next;
        end
    end

endmodule

FILE: rtl/rscp_back.sv
module rscp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  rscp_pkg::job_t  head_job,
    input  logic            head_valid,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_port,
    output logic [7:0]      out_byte,
    output logic            end_of_run,
    output logic [15:0]     pan_id_now,
    output logic [15:0]     short_addr_now
);

    logic [rscp_pkg::STEP_W-1:0]    step_reg;
    logic [rscp_pkg::STEP_W-1:0]    step_m2, step_m3, step_m4;
    logic                           out_valid_reg;
    logic                           port_reg;
    logic [7:0]                     byte_reg;
    logic                           end_reg;
    logic [15:0]                    pan_reg;
    logic [15:0]                    short_reg;
    logic                           w_port;
    logic [7:0]                     w_byte;
    logic                           w_end;
    logic                           w_last;
    logic                           load;

    // success reply word by position
    function automatic logic [7:0] ok_byte(input logic [1:0] idx, input logic [7:0] cmd);
        logic [7:0] b;
        case (idx)
            2'd0:    b = rscp_pkg::SYNC_A;
            2'd1:    b = rscp_pkg::SYNC_B;
            2'd2:    b = cmd | rscp_pkg::RESP_BIT;
            default: b = rscp_pkg::OK_CODE;
        endcase
        return b;
    endfunction

    assign step_m2 = step_reg - rscp_pkg::STEP_W'(2);
    assign step_m3 = step_reg - rscp_pkg::STEP_W'(3);
    assign step_m4 = step_reg - rscp_pkg::STEP_W'(4);

    // word for the current step of the head job
    always_comb
    begin
        w_port = 1'b0;
        w_byte = '0;
        w_end  = 1'b0;
        w_last = 1'b0;
        case (head_job.kind)
            rscp_pkg::JOB_BYTE:
            begin
                w_port = 1'b1;
                w_byte = head_job.data;
                w_last = 1'b1;
            end
            rscp_pkg::JOB_LAST:
            begin
                if (step_reg == rscp_pkg::STEP_W'(0))
                begin
                    w_port = 1'b1;
                    w_byte = head_job.data;
                end
                else if (step_reg == rscp_pkg::STEP_W'(1))
                begin
                    w_port = 1'b1;
                    w_byte = head_job.fcs[7:0];
                end
                else if (step_reg == rscp_pkg::STEP_W'(2))
                begin
                    w_port = 1'b1;
                    w_byte = head_job.fcs[15:8];
                    w_end  = 1'b1;
                end
                else
                begin
                    w_byte = ok_byte(step_m3[1:0], head_job.cmd);
                    w_last = (step_reg == rscp_pkg::STEP_W'(6));
                    w_end  = w_last;
                end
            end
            rscp_pkg::JOB_FCS:
            begin
                if (step_reg == rscp_pkg::STEP_W'(0))
                begin
                    w_port = 1'b1;
                    w_byte = head_job.fcs[7:0];
                end
                else if (step_reg == rscp_pkg::STEP_W'(1))
                begin
                    w_port = 1'b1;
                    w_byte = head_job.fcs[15:8];
                    w_end  = 1'b1;
                end
                else
                begin
                    w_byte = ok_byte(step_m2[1:0], head_job.cmd);
                    w_last = (step_reg == rscp_pkg::STEP_W'(5));
                    w_end  = w_last;
                end
            end
            rscp_pkg::JOB_ADDR:
            begin
                if (step_reg < rscp_pkg::STEP_W'(4))
                begin
                    w_byte = ok_byte(step_reg[1:0], head_job.cmd);
                end
                else
                begin
                    w_byte = head_job.long_addr[step_m4[rscp_pkg::LONG_IDX_W-1:0]];
                    w_last = (step_reg == rscp_pkg::STEP_W'(3 + rscp_pkg::LONG_ADDR_BYTES));
                    w_end  = w_last;
                end
            end
            default:
            begin
                w_byte = ok_byte(step_reg[1:0], head_job.cmd);
                w_last = (step_reg == rscp_pkg::STEP_W'(3));
                w_end  = w_last;
            end
        endcase
    end

    // output register refills when empty or taken
    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && w_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg      <= w_last ? '0 : step_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            port_reg  <= w_port;
            byte_reg  <= w_byte;
            end_reg   <= w_end;
            pan_reg   <= head_job.pan_id;
            short_reg <= head_job.short_addr;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_port       = port_reg;
    assign out_byte       = byte_reg;
    assign end_of_run     = end_reg;
    assign pan_id_now     = pan_reg;
    assign short_addr_now = short_reg;

endmodule

FILE: rtl/radio_serial_command_parser_core.sv
// Serial command parser for an 802.15.4 radio front end.
// rx channel: one host byte per word (rx_valid/rx_ready/rx_byte). The parser
//   hunts the sync pair, decodes the command and its arguments and keeps the
//   PAN id, short address and long address.
// out channel: one word per output byte (out_valid/out_ready). out_port 0 is
//   a reply to the host, 1 a frame byte to the network; end_of_run marks the
//   last byte of a reply or frame. pan_id_now/short_addr_now travel with each
//   word.
// Throughput: one rx word per cycle while the queue is not full. Each word
//   that yields output becomes a job in a 4-deep queue; the emitter drains
//   one word per ready cycle; a job is 1 to 12 words, get-address the longest.
// Path: the job for an rx word is registered in the queue, and each of its
//   words is registered in the output register before it appears on out.
// Stall: when out_ready is low the output register holds; the queue fills
//   and rx_ready drops once it holds 4 jobs.
// Reset (rst_n low, async): parser back to sync hunt, stored addresses and
//   FCS cleared, queue and output emptied.
module radio_serial_command_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_port,
    output logic [7:0]  out_byte,
    output logic        end_of_run,
    output logic [15:0] pan_id_now,
    output logic [15:0] short_addr_now
);

    rscp_pkg::job_t push_job;
    rscp_pkg::job_t head_job;
    logic           push;
    logic           pop;
    logic           head_valid;
    logic           full;
    logic           take;

    assign rx_ready = !full;
    assign take     = rx_valid && rx_ready;

    rscp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx_byte),
        .job_valid (push),
        .job       (push_job)
    );

    rscp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_job   (head_job),
        .head_valid (head_valid),
        .full       (full)
    );

    rscp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_job       (head_job),
        .head_valid     (head_valid),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_port       (out_port),
        .out_byte       (out_byte),
        .end_of_run     (end_of_run),
        .pan_id_now     (pan_id_now),
        .short_addr_now (short_addr_now)
    );

endmodule

FILE: rtl/rscp_checker.sv
`include "assert_macros.svh"

module rscp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        out_port,
    input  logic [7:0]  out_byte,
    input  logic        end_of_run,
    input  logic [15:0] pan_id_now
);

    logic           out_take;
    logic           frame_end_reg;
    logic           mid_run_reg;
    logic [15:0]    prev_pan_reg;

    assign out_take = out_valid && out_ready;

    // history of the last taken word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_end_reg <= 1'b0;
            mid_run_reg   <= 1'b0;
            prev_pan_reg  <= '0;
        end
        else if (out_take)
        begin
            frame_end_reg <= out_port && end_of_run;
            mid_run_reg   <= !end_of_run;
            prev_pan_reg  <= pan_id_now;
        end
    end

    // stalled word stays up
    `RSCP_CLK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)

    // stalled word keeps its payload
    `RSCP_CLK_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_byte) && $stable(out_port))

    // a finished frame is followed by the host reply
    `RSCP_CLK_ASSERT(a_reply_after_frame, out_valid && frame_end_reg |-> !out_port && out_byte == rscp_pkg::SYNC_A)

    // PAN id cannot move inside a run
    `RSCP_CLK_ASSERT(a_pan_in_run, out_valid && mid_run_reg |-> pan_id_now == prev_pan_reg)

endmodule

bind radio_serial_command_parser_core rscp_checker u_rscp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_port   (out_port),
    .out_byte   (out_byte),
    .end_of_run (end_of_run),
    .pan_id_now (pan_id_now)
);

FILE: bench/tb_radio_serial_command_parser_core.sv
`timescale 1ns / 1ps

module tb_radio_serial_command_parser_core;

    // Parser phases of the predictor
    typedef enum logic [2:0] {
        HUNT_SYNC_A,
        HUNT_SYNC_B,
        READ_CMD,
        READ_ARGS,
        READ_TX_LEN,
        READ_PAYLOAD
    } parse_phase_t;

    // One expected output word
    typedef struct {
        logic        port;
        logic [7:0]  data;
        logic        is_last;
        logic [15:0] pan_id;
        logic [15:0] short_addr;
    } out_word_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        rx_valid       = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_byte        = 8'h00;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic        out_port;
    logic [7:0]  out_byte;
    logic        end_of_run;
    logic [15:0] pan_id_now;
    logic [15:0] short_addr_now;

    // Predictor state
    parse_phase_t model_phase;
    logic [7:0]   model_cmd;
    logic [7:0]   model_arg_cnt;
    logic [7:0]   model_tx_left;
    logic [15:0]  model_fcs;
    logic [15:0]  model_pan_id;
    logic [15:0]  model_short_addr;
    logic [7:0]   model_long_addr [rscp_pkg::LONG_ADDR_BYTES];

    out_word_t expected_words[$];
    out_word_t want;

    int sender_idle_pct = 0;
    int recv_idle_pct   = 0;
    int mismatch_count  = 0;
    int words_checked   = 0;
    int busy_bytes      = 0;
    int frames_sent     = 0;
    int tx_frames       = 0;

    radio_serial_command_parser_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_valid       (rx_valid),
        .rx_ready       (rx_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_port       (out_port),
        .out_byte       (out_byte),
        .end_of_run     (end_of_run),
        .pan_id_now     (pan_id_now),
        .short_addr_now (short_addr_now)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d words still expected", expected_words.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [15:0] fcs_next(input logic [15:0] crc_in,
                                             input logic [7:0] data_in);
        logic [15:0] c;
        begin
            c = crc_in ^ {8'h00, data_in};
            for (int i = 0; i < 8; i++)
                c = c[0] ? ((c >> 1) ^ rscp_pkg::FCS_POLY) : (c >> 1);
            return c;
        end
    endfunction

    task automatic reset_model();
        begin
            model_phase      = HUNT_SYNC_A;
            model_cmd        = 8'h00;
            model_arg_cnt    = 8'h00;
            model_tx_left    = 8'h00;
            model_fcs        = rscp_pkg::FCS_INIT;
            model_pan_id     = 16'h0000;
            model_short_addr = 16'h0000;
            for (int i = 0; i < rscp_pkg::LONG_ADDR_BYTES; i++)
                model_long_addr[i] = 8'h00;
        end
    endtask

    task automatic push_word(input logic port, input logic [7:0] data,
                             input logic is_last);
        out_word_t w;
        begin
            w.port       = port;
            w.data       = data;
            w.is_last    = is_last;
            w.pan_id     = model_pan_id;
            w.short_addr = model_short_addr;
            expected_words.push_back(w);
        end
    endtask

    task automatic push_ok_reply();
        begin
            push_word(1'b0, rscp_pkg::SYNC_A, 1'b0);
            push_word(1'b0, rscp_pkg::SYNC_B, 1'b0);
            push_word(1'b0, model_cmd | rscp_pkg::RESP_BIT, 1'b0);
            push_word(1'b0, rscp_pkg::OK_CODE, 1'b1);
        end
    endtask

    // FCS low then high on the network port, then the host reply
    task automatic push_frame_tail();
        begin
            push_word(1'b1, model_fcs[7:0], 1'b0);
            push_word(1'b1, model_fcs[15:8], 1'b1);
            push_ok_reply();
            model_phase = HUNT_SYNC_A;
        end
    endtask

    task automatic predict_host_byte(input logic [7:0] b);
        int needed;
        begin
            case (model_phase)
                HUNT_SYNC_B:
                    model_phase = (b == rscp_pkg::SYNC_B) ? READ_CMD : HUNT_SYNC_A;
                READ_CMD:
                begin
                    model_cmd     = b;
                    model_arg_cnt = 8'h00;
                    if (b == rscp_pkg::CMD_PANID || b == rscp_pkg::CMD_SHORT ||
                        b == rscp_pkg::CMD_LONG || b == rscp_pkg::CMD_CHANNEL)
                        model_phase = READ_ARGS;
                    else if (b == rscp_pkg::CMD_TX)
                        model_phase = READ_TX_LEN;
                    else if (b == rscp_pkg::CMD_GETADDR)
                    begin
                        push_word(1'b0, rscp_pkg::SYNC_A, 1'b0);
                        push_word(1'b0, rscp_pkg::SYNC_B, 1'b0);
                        push_word(1'b0, b | rscp_pkg::RESP_BIT, 1'b0);
                        push_word(1'b0, rscp_pkg::OK_CODE, 1'b0);
                        for (int i = 0; i < rscp_pkg::LONG_ADDR_BYTES; i++)
                            push_word(1'b0, model_long_addr[i],
                                      i == rscp_pkg::LONG_ADDR_BYTES - 1);
                        model_phase = HUNT_SYNC_A;
                    end
                    else
                    begin
                        push_ok_reply();
                        model_phase = HUNT_SYNC_A;
                    end
                end
                READ_ARGS:
                begin
                    // address bytes land as they arrive, high byte first
                    if (model_cmd == rscp_pkg::CMD_PANID)
                    begin
                        if (model_arg_cnt == 0)
                            model_pan_id[15:8] = b;
                        else
                            model_pan_id[7:0] = b;
                    end
                    else if (model_cmd == rscp_pkg::CMD_SHORT)
                    begin
                        if (model_arg_cnt == 0)
                            model_short_addr[15:8] = b;
                        else
                            model_short_addr[7:0] = b;
                    end
                    else if (model_cmd == rscp_pkg::CMD_LONG &&
                             model_arg_cnt < rscp_pkg::LONG_ADDR_BYTES)
                        model_long_addr[model_arg_cnt[rscp_pkg::LONG_IDX_W-1:0]] = b;
                    model_arg_cnt = model_arg_cnt + 8'd1;
                    if (model_cmd == rscp_pkg::CMD_PANID || model_cmd == rscp_pkg::CMD_SHORT)
                        needed = 2;
                    else if (model_cmd == rscp_pkg::CMD_LONG)
                        needed = rscp_pkg::LONG_ADDR_BYTES;
                    else
                        needed = 1;
                    if (model_arg_cnt >= needed)
                    begin
                        push_ok_reply();
                        model_phase = HUNT_SYNC_A;
                    end
                end
                READ_TX_LEN:
                begin
                    model_tx_left = b;
                    model_fcs     = rscp_pkg::FCS_INIT;
                    if (b == 8'h00)
                        push_frame_tail();
                    else
                        model_phase = READ_PAYLOAD;
                end
                READ_PAYLOAD:
                begin
                    push_word(1'b1, b, 1'b0);
                    model_fcs     = fcs_next(model_fcs, b);
                    model_tx_left = model_tx_left - 8'd1;
                    if (model_tx_left == 8'h00)
                        push_frame_tail();
                end
                default:
                    model_phase = (b == rscp_pkg::SYNC_A) ? HUNT_SYNC_B : HUNT_SYNC_A;
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Send one host word, each cycle in front of it idle at the sender's rate
    task automatic send_host_byte(input logic [7:0] b);
        begin
            while ($urandom_range(99) < sender_idle_pct)
            begin
                rx_valid <= 1'b0;
                @(posedge clk);
            end
            rx_valid <= 1'b1;
            rx_byte  <= b;
            do
                @(posedge clk);
            while (!rx_ready);
            if (model_phase != HUNT_SYNC_A || b == rscp_pkg::SYNC_A)
                busy_bytes++;
            predict_host_byte(b);
        end
    endtask

    task automatic send_frame_header(input logic [7:0] cmd);
        begin
            send_host_byte(rscp_pkg::SYNC_A);
            send_host_byte(rscp_pkg::SYNC_B);
            send_host_byte(cmd);
            frames_sent++;
            if (cmd == rscp_pkg::CMD_TX)
                tx_frames++;
        end
    endtask

    // Hold off the sender until every expected word is out
    task automatic wait_until_drained();
        begin
            rx_valid <= 1'b0;
            while (expected_words.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string field, input logic [15:0] exp_val,
                                   input logic [15:0] got_val);
        begin
            $display("%0t: mismatch on %s: expected %h, got %h",
                     $realtime, field, exp_val, got_val);
            mismatch_count++;
        end
    endtask

    // Random receiver stall plus compare of each accepted word
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word", 16'h0000, {8'h00, out_byte});
            else
            begin
                want = expected_words.pop_front();
                if (out_port !== want.port)
                    report_mismatch("out_port", 16'(want.port), 16'(out_port));
                if (out_byte !== want.data)
                    report_mismatch("out_byte", 16'(want.data), 16'(out_byte));
                if (end_of_run !== want.is_last)
                    report_mismatch("end_of_run", 16'(want.is_last), 16'(end_of_run));
                if (pan_id_now !== want.pan_id)
                    report_mismatch("pan_id_now", want.pan_id, pan_id_now);
                if (short_addr_now !== want.short_addr)
                    report_mismatch("short_addr_now", want.short_addr, short_addr_now);
                words_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Noise, a bad second sync word that is itself 'z', then get-address
    // on the reset long address
    task automatic test_sync_hunt();
        begin
            send_host_byte(8'h00);
            send_host_byte(8'hff);
            send_host_byte(rscp_pkg::SYNC_A);
            send_host_byte(rscp_pkg::SYNC_A);
            send_frame_header(rscp_pkg::CMD_GETADDR);
        end
    endtask

    task automatic test_address_commands();
        logic [7:0] long_pattern [rscp_pkg::LONG_ADDR_BYTES];
        begin
            long_pattern = '{8'hff, 8'h00, 8'h01, 8'h80, 8'h7f, 8'hfe,
                             rscp_pkg::SYNC_A, rscp_pkg::SYNC_B};
            send_frame_header(rscp_pkg::CMD_PANID);
            send_host_byte(8'hff);
            send_host_byte(8'hff);
            send_frame_header(rscp_pkg::CMD_LONG);
            for (int i = 0; i < rscp_pkg::LONG_ADDR_BYTES; i++)
                send_host_byte(long_pattern[i]);
            send_frame_header(rscp_pkg::CMD_GETADDR);
        end
    endtask

    // Empty frame, then a one-word frame
    task automatic test_transmit();
        begin
            send_frame_header(rscp_pkg::CMD_TX);
            send_host_byte(8'h00);
            send_frame_header(rscp_pkg::CMD_TX);
            send_host_byte(8'h01);
            send_host_byte(8'hff);
        end
    endtask

    task automatic test_other_commands();
        begin
            send_frame_header(rscp_pkg::CMD_CHANNEL);
            send_host_byte(8'h00);
            send_frame_header(8'hff);
        end
    endtask

    // One random frame: mostly well formed, some noise and broken syncs
    task automatic random_command_frame();
        int         pick;
        int         len;
        logic [7:0] b;
        logic [7:0] cmd;
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                wait_until_drained();
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    do
                        b = 8'($urandom_range(255));
                    while (b == rscp_pkg::SYNC_A);
                    send_host_byte(b);
                end
            end
            else if (pick < 14)
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == rscp_pkg::SYNC_B);
                send_host_byte(rscp_pkg::SYNC_A);
                send_host_byte(b);
            end
            else if (pick < 26)
            begin
                send_frame_header(rscp_pkg::CMD_PANID);
                repeat (2) send_host_byte(8'($urandom_range(255)));
            end
            else if (pick < 38)
            begin
                send_frame_header(rscp_pkg::CMD_SHORT);
                repeat (2) send_host_byte(8'($urandom_range(255)));
            end
            else if (pick < 46)
            begin
                send_frame_header(rscp_pkg::CMD_LONG);
                repeat (rscp_pkg::LONG_ADDR_BYTES) send_host_byte(8'($urandom_range(255)));
            end
            else if (pick < 54)
            begin
                send_frame_header(rscp_pkg::CMD_CHANNEL);
                send_host_byte(8'($urandom_range(255)));
            end
            else if (pick < 64)
                send_frame_header(rscp_pkg::CMD_GETADDR);
            else if (pick < 88)
            begin
                // mostly short frames, now and then a long one
                len = ($urandom_range(99) < 92) ? $urandom_range(10) : $urandom_range(255);
                send_frame_header(rscp_pkg::CMD_TX);
                send_host_byte(8'(len));
                repeat (len) send_host_byte(8'($urandom_range(255)));
            end
            else
            begin
                do
                    cmd = 8'($urandom_range(255));
                while (cmd == rscp_pkg::CMD_PANID || cmd == rscp_pkg::CMD_SHORT ||
                       cmd == rscp_pkg::CMD_LONG || cmd == rscp_pkg::CMD_CHANNEL ||
                       cmd == rscp_pkg::CMD_TX || cmd == rscp_pkg::CMD_GETADDR);
                send_frame_header(cmd);
            end
        end
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int target;
        begin
            target = busy_bytes + n_bytes;
            while (busy_bytes < target)
                random_command_frame();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_model();
        sender_idle_pct = 19;
        recv_idle_pct   = 61;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sync_hunt();
        test_address_commands();
        test_transmit();
        test_other_commands();
        wait_until_drained();

        test_random_traffic(110);
        wait_until_drained();

        sender_idle_pct = 61;
        recv_idle_pct   = 19;
        test_random_traffic(110);
        wait_until_drained();

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        test_random_traffic(110);
        wait_until_drained();
        repeat (20) @(posedge clk);

        $display("Sent %0d command frames (%0d transmit) in %0d parsed host words,",
                 frames_sent, tx_frames, busy_bytes);
        $display("checked %0d output words, %0d mismatches", words_checked,
                 mismatch_count);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rscp_pkg.sv
rtl/rscp_fifo.sv
rtl/rscp_front.sv
rtl/rscp_back.sv
rtl/radio_serial_command_parser_core.sv
rtl/rscp_checker.sv
bench/tb_radio_serial_command_parser_core.sv
